// ----- hw/rtl/srs_pkg.sv -----
package srs_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned COIL_W      = 6;
  localparam int unsigned DELAY_W     = 8;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [IDX_W-1:0]   MAX_STEPS     = 10'd1023;
  localparam logic [POS_W:0]     STEPS_PER_REV = 9'd200;
  localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 8'd20;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 8'd12;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_HOME  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DELAY = 1'b0,
    REG_MIN_DELAY = 1'b1
  } cfg_reg_t;

  // Full-step coil drive patterns in phase order
  function automatic logic [COIL_W-1:0] coil_of(input logic [1:0] ph);
    logic [COIL_W-1:0] pat;
    case (ph)
      2'd0:    pat = 6'h32;
      2'd1:    pat = 6'h16;
      2'd2:    pat = 6'h29;
      default: pat = 6'h0D;
    endcase
    return pat;
  endfunction

endpackage

// ----- hw/rtl/srs_in_if.sv -----
interface srs_in_if import srs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [COUNT_W-1:0] step_count;
  logic                      hall_high;

  modport source (output valid, output cmd, output step_count, output hall_high,
                  input ready);
  modport sink   (input valid, input cmd, input step_count, input hall_high,
                  output ready);
endinterface

// ----- hw/rtl/srs_out_if.sv -----
interface srs_out_if import srs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COIL_W-1:0]  coil_pattern;
  logic [DELAY_W-1:0] delay_ms;
  logic [POS_W-1:0]   position;
  logic               last;

  modport source (output valid, output coil_pattern, output delay_ms, output position,
                  output last, input ready);
  modport sink   (input valid, input coil_pattern, input delay_ms, input position,
                  input last, output ready);
endinterface

// ----- hw/rtl/stepper_ramp_sequencer.sv -----
// Four-phase full-step stepper sequencer with a linear delay ramp. A start request loads a
// signed step count (saturated to 1023 steps); each step tick then yields one coil pattern,
// the delay to hold it, the shaft position after the step (0..199) and a flag on the final
// step. A home tick steps at max_delay while hall_high is 1 and zeroes the position when it
// reads 0. For every request the state update and the result are computed in a single
// pass and the result lands in an output register, so a request is taken each cycle
// as long as the result register is empty or being drained. Start requests, idle step ticks,
// home ticks with hall_high 0 and command code 3 give no result. Write max_delay and
// min_delay only while idle; a min_delay above max_delay acts as max_delay.
module stepper_ramp_sequencer import srs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  srs_in_if.sink                in_ch,
  srs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DELAY_W-1:0] max_delay_r, min_delay_r;
  logic               busy_r, busy_nxt;
  logic [IDX_W-1:0]   step_index_r, step_index_nxt;
  logic [IDX_W-1:0]   move_length_r, move_length_nxt;
  logic               reverse_r, reverse_nxt;
  logic               long_move_r, long_move_nxt;
  logic [DELAY_W-1:0] cur_delay_r, cur_delay_nxt;
  logic [1:0]         phase_offset_r, phase_offset_nxt;
  logic [1:0]         phase_index_r, phase_index_nxt;
  logic [POS_W-1:0]   shaft_pos_r, shaft_pos_nxt;
  logic [POS_W-1:0]   home_cnt_r, home_cnt_nxt;

  logic               out_valid_r;
  logic [COIL_W-1:0]  out_coil_r, coil_nxt;
  logic [DELAY_W-1:0] out_delay_r, delay_nxt;
  logic [POS_W-1:0]   out_pos_r;
  logic               out_last_r, last_nxt;
  logic               res_valid;

  logic               accept;
  cmd_t               cmd;
  logic [DELAY_W-1:0] eff_min, diff;
  logic               neg;
  logic [COUNT_W-1:0] mag_raw;
  logic [IDX_W-1:0]   mag;
  logic [IDX_W-1:0]   remain;
  logic               go_down;
  logic [1:0]         ph_fwd, ph;
  logic [POS_W:0]     pos_inc, home_inc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.cmd);

  assign eff_min = (min_delay_r > max_delay_r) ? max_delay_r : min_delay_r;
  assign diff    = max_delay_r - eff_min;

  assign neg     = in_ch.step_count[COUNT_W-1];
  assign mag_raw = neg ? (COUNT_W'(0) - COUNT_W'(in_ch.step_count))
                       : COUNT_W'(in_ch.step_count);
  assign mag     = (mag_raw > COUNT_W'(MAX_STEPS)) ? MAX_STEPS : mag_raw[IDX_W-1:0];

  assign remain  = move_length_r - step_index_r;
  assign go_down = long_move_r ? (remain > IDX_W'(diff))
                               : (step_index_r <= (move_length_r >> 1));

  assign ph_fwd   = phase_offset_r + step_index_r[1:0];
  assign ph       = reverse_r ? (2'd0 - ph_fwd) : ph_fwd;
  assign pos_inc  = {1'b0, shaft_pos_r} + 9'd1;
  assign home_inc = {1'b0, home_cnt_r} + 9'd1;

  always_comb begin
    busy_nxt         = busy_r;
    step_index_nxt   = step_index_r;
    move_length_nxt  = move_length_r;
    reverse_nxt      = reverse_r;
    long_move_nxt    = long_move_r;
    cur_delay_nxt    = cur_delay_r;
    phase_offset_nxt = phase_offset_r;
    phase_index_nxt  = phase_index_r;
    shaft_pos_nxt    = shaft_pos_r;
    home_cnt_nxt     = home_cnt_r;
    res_valid        = 1'b0;
    coil_nxt         = coil_of(ph);
    delay_nxt        = cur_delay_r;
    last_nxt         = 1'b0;
    case (cmd)
      CMD_START: begin
        home_cnt_nxt = '0;
        if (mag == '0) begin
          busy_nxt = 1'b0;
        end else begin
          busy_nxt         = 1'b1;
          step_index_nxt   = '0;
          move_length_nxt  = mag;
          reverse_nxt      = neg;
          long_move_nxt    = {1'b0, mag} >= {2'b00, diff, 1'b0};
          cur_delay_nxt    = max_delay_r;
          phase_offset_nxt = phase_index_r + 2'd1;
        end
      end
      CMD_STEP: begin
        if (busy_r) begin
          if (go_down) begin
            cur_delay_nxt = (cur_delay_r > eff_min) ? cur_delay_r - 8'd1 : eff_min;
          end else begin
            cur_delay_nxt = (cur_delay_r < max_delay_r) ? cur_delay_r + 8'd1 : max_delay_r;
          end
          if (reverse_r) begin
            shaft_pos_nxt = (shaft_pos_r == '0 || {1'b0, shaft_pos_r} >= STEPS_PER_REV)
                          ? POS_W'(STEPS_PER_REV - 9'd1) : shaft_pos_r - 8'd1;
          end else begin
            shaft_pos_nxt = (pos_inc >= STEPS_PER_REV) ? '0 : pos_inc[POS_W-1:0];
          end
          phase_index_nxt = ph;
          step_index_nxt  = step_index_r + 10'd1;
          last_nxt        = step_index_nxt >= move_length_r;
          busy_nxt        = !last_nxt;
          res_valid       = 1'b1;
          delay_nxt       = cur_delay_nxt;
        end
      end
      CMD_HOME: begin
        busy_nxt = 1'b0;
        if (!in_ch.hall_high) begin
          shaft_pos_nxt = '0;
          home_cnt_nxt  = '0;
        end else begin
          phase_index_nxt = home_cnt_r[1:0];
          home_cnt_nxt    = (home_inc >= STEPS_PER_REV) ? '0 : home_inc[POS_W-1:0];
          coil_nxt        = coil_of(home_cnt_r[1:0]);
          delay_nxt       = max_delay_r;
          res_valid       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r    <= MAX_DELAY_RST;
      min_delay_r    <= MIN_DELAY_RST;
      busy_r         <= 1'b0;
      step_index_r   <= '0;
      move_length_r  <= '0;
      reverse_r      <= 1'b0;
      long_move_r    <= 1'b0;
      cur_delay_r    <= MAX_DELAY_RST;
      phase_offset_r <= '0;
      phase_index_r  <= 2'd3;
      shaft_pos_r    <= '0;
      home_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_MAX_DELAY: max_delay_r <= cfg_data;
          REG_MIN_DELAY: min_delay_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        busy_r         <= busy_nxt;
        step_index_r   <= step_index_nxt;
        move_length_r  <= move_length_nxt;
        reverse_r      <= reverse_nxt;
        long_move_r    <= long_move_nxt;
        cur_delay_r    <= cur_delay_nxt;
        phase_offset_r <= phase_offset_nxt;
        phase_index_r  <= phase_index_nxt;
        shaft_pos_r    <= shaft_pos_nxt;
        home_cnt_r     <= home_cnt_nxt;
        out_valid_r    <= res_valid;
      end else if (out_ch.ready) begin
        // drop the result once taken
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: load with every accepted request that yields a result
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_coil_r  <= coil_nxt;
      out_delay_r <= delay_nxt;
      out_pos_r   <= shaft_pos_nxt;
      out_last_r  <= last_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.coil_pattern = out_coil_r;
  assign out_ch.delay_ms     = out_delay_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.last         = out_last_r;

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd == CMD_STEP && busy_r) |=> out_valid_r)
    else $error("step tick on a running move gave no result");

  a_silent_request_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !res_valid) |=> !out_valid_r)
    else $error("stale result left after a request without result");

  a_last_means_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !busy_r)
    else $error("move still busy after its final step");

endmodule
